FILE: hw/rtl/bccw_pkg.sv
// Shared constants for the bivariate cubic coordinate warp.
// Fixed-point formats, store geometry, command codes and term order.
// No dependencies.
`default_nettype none

package bccw_pkg;

    // Default field widths
    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF  = 48;

    // Fraction bits of coordinates (Q.20) and coefficients (Q.32)
    localparam int COORD_FRAC = 20;
    localparam int COEF_FRAC  = 32;

    // Coefficient store: two sets, two axes, ten terms
    localparam int N_TERM = 10;
    localparam int N_AXIS = 2;
    localparam int N_SET  = 2;
    localparam int N_SLOT = N_SET * N_AXIS * N_TERM;
    localparam int IDX_W  = 6;

    // Item kinds carried in tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_XFORM = 1'b1;

    // Term order within one axis
    localparam int TERM_ONE = 0;
    localparam int TERM_X   = 1;
    localparam int TERM_Y   = 2;
    localparam int TERM_X2  = 3;
    localparam int TERM_XY  = 4;
    localparam int TERM_Y2  = 5;
    localparam int TERM_X3  = 6;
    localparam int TERM_X2Y = 7;
    localparam int TERM_XY2 = 8;
    localparam int TERM_Y3  = 9;

endpackage

`default_nettype wire

FILE: hw/rtl/bivariate_cubic_coordinate_warp.sv
// Usage
// Slave channel (i_s_*): one transaction per item. tuser carries the command:
// a load writes one coefficient into the store and produces no result; a
// transform maps (in_x, in_y) through the cubic of the chosen direction.
// Master channel (o_m_*): one transaction per transform, in input order,
// carrying the saturated coordinates in tdata and the clip flag in tuser.
// Pipeline: twelve register stages (the input register, squares, cube
// partial products, cube sums, coefficient partial products, two
// recombination adds and a four-level adder tree, then saturation into
// the output register). Throughput: one item per cycle while i_m_tready
// is high, set by the fully pipelined multipliers.
// A load takes effect for every transform accepted after it.
// Reset (synchronous, active low) empties the pipeline and clears all
// forty coefficients to zero.
// Stall: when i_m_tready is low, the result holds in the output register
// and empty stages keep filling; o_s_tready drops only once every stage
// holds an item, so nothing is lost or repeated.
// Depends on bccw_pkg.
`default_nettype none

module bivariate_cubic_coordinate_warp #(
    parameter int COORD_WIDTH = bccw_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = bccw_pkg::COEF_WIDTH_DEF,
    localparam int S_DATA_W =
        ((1 + bccw_pkg::IDX_W + COEF_WIDTH + 2 * COORD_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // slave side
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // direction, coef_index, coef_value, in_x, in_y
    input  logic                i_s_tuser,   // command
    // master side
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // out_x, out_y
    output logic                o_m_tuser    // clipped
);
    import bccw_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int C  = COEF_WIDTH;
    localparam int F  = COORD_FRAC;
    localparam int CF = COEF_FRAC;

    // tdata field offsets
    localparam int OFF_DIR  = 0;
    localparam int OFF_IDX  = OFF_DIR + 1;
    localparam int OFF_COEF = OFF_IDX + IDX_W;
    localparam int OFF_X    = OFF_COEF + C;
    localparam int OFF_Y    = OFF_X + W;

    // power widths
    localparam int SQ_W = 2 * W;
    localparam int P2   = 2 * W - F;
    localparam int P3   = 3 * W - 2 * F;
    localparam int PW   = (P3 > F + 1) ? P3 : F + 2;

    // cube partial products: linear term times split square
    localparam int Q2L         = P2 / 2;
    localparam int Q2H         = P2 - Q2L;
    localparam int CUBE_LO_W   = W + Q2L + 1;
    localparam int CUBE_HI_W   = W + Q2H;
    localparam int CUBE_FULL_W = W + P2;
    localparam int N_CUBE      = 4;

    // coefficient partial products
    localparam int PL     = PW / 2;
    localparam int PH     = PW - PL;
    localparam int CL     = C / 2;
    localparam int CH     = C - CL;
    localparam int LL_W   = PL + CL;
    localparam int LH_W   = PL + 1 + CH;
    localparam int HL_W   = PH + CL + 1;
    localparam int HH_W   = PH + CH;
    localparam int PROD_W = PW + C;
    localparam int SUM_W  = PROD_W + 4;
    localparam int Q_W    = SUM_W - CF;

    localparam int NST = 12;

    typedef logic signed [W-1:0]  t_coord;
    typedef logic signed [P2-1:0] t_quad;
    typedef logic signed [PW-1:0] t_pow;
    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic             cmd;
        logic             dir;
        logic [IDX_W-1:0] idx;
        logic [C-1:0]     cval;
    } t_ctl;

    // stage handshake
    logic [NST:0]   en;
    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;

    // coefficient store
    logic [C-1:0] r_coef [0:N_SLOT-1];
    logic         coef_wr;

    // stages 0..3 control and coordinates
    t_ctl   r_ctl [0:3];
    t_coord r_x   [0:2];
    t_coord r_y   [0:2];

    // stage 1: squares
    logic signed [SQ_W-1:0] r_s1_xx, r_s1_xy, r_s1_yy;

    // stage 2: square powers and cube partial products
    t_quad r_s2_x2, r_s2_xy, r_s2_y2;
    logic signed [CUBE_LO_W-1:0] r_s2_clo [0:N_CUBE-1];
    logic signed [CUBE_HI_W-1:0] r_s2_chi [0:N_CUBE-1];
    logic signed [CUBE_LO_W-1:0] n_s2_clo [0:N_CUBE-1];
    logic signed [CUBE_HI_W-1:0] n_s2_chi [0:N_CUBE-1];

    // stage 3: all ten powers
    t_pow r_s3_pw [0:N_TERM-1];
    t_pow n_s3_pw [0:N_TERM-1];

    // stage 4: coefficient partial products
    logic        [LL_W-1:0] r_s4_ll [0:N_AXIS-1][0:N_TERM-1];
    logic signed [LH_W-1:0] r_s4_lh [0:N_AXIS-1][0:N_TERM-1];
    logic signed [HL_W-1:0] r_s4_hl [0:N_AXIS-1][0:N_TERM-1];
    logic signed [HH_W-1:0] r_s4_hh [0:N_AXIS-1][0:N_TERM-1];
    logic        [LL_W-1:0] n_s4_ll [0:N_AXIS-1][0:N_TERM-1];
    logic signed [LH_W-1:0] n_s4_lh [0:N_AXIS-1][0:N_TERM-1];
    logic signed [HL_W-1:0] n_s4_hl [0:N_AXIS-1][0:N_TERM-1];
    logic signed [HH_W-1:0] n_s4_hh [0:N_AXIS-1][0:N_TERM-1];

    // stages 5..10: recombination and adder tree
    logic signed [PROD_W-1:0] r_s5_a [0:N_AXIS-1][0:N_TERM-1];
    logic signed [PROD_W-1:0] r_s5_b [0:N_AXIS-1][0:N_TERM-1];
    logic signed [PROD_W-1:0] r_s6_p [0:N_AXIS-1][0:N_TERM-1];
    t_sum r_s7_s  [0:N_AXIS-1][0:4];
    t_sum r_s8_s  [0:N_AXIS-1][0:2];
    t_sum r_s9_s  [0:N_AXIS-1][0:1];
    t_sum r_s10_s [0:N_AXIS-1];

    // stage 11: output register
    t_coord r_s11_out [0:N_AXIS-1];
    logic   r_s11_clip;
    t_coord n_s11_out [0:N_AXIS-1];
    logic   n_s11_clip;

    // ------------------------------------------------------------------
    // Handshake: a stage advances when it is empty or the next one advances
    // ------------------------------------------------------------------
    assign en[NST] = i_m_tready;

    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = ~r_v[k] | en[k+1];
    end

    always_comb begin
        for (int k = 0; k < NST; k++) begin
            n_v[k] = (k == 0) ? i_s_tvalid : r_v[(k == 0) ? 0 : k - 1];
        end
        // loads retire once they reach the store
        n_v[4] = r_v[3] && (r_ctl[3].cmd == CMD_XFORM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_v[NST-1];
    assign o_m_tdata  = M_DATA_W'({r_s11_out[1], r_s11_out[0]});
    assign o_m_tuser  = r_s11_clip;

    // ------------------------------------------------------------------
    // Coefficient store: written as a load leaves stage 3, so transforms
    // ahead of it have already read and those behind it see the new value
    // ------------------------------------------------------------------
    assign coef_wr = r_v[3] && en[4] && (r_ctl[3].cmd == CMD_LOAD)
                     && (r_ctl[3].idx < IDX_W'(N_SLOT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N_SLOT; s++) begin
                r_coef[s] <= '0;
            end
        end else if (coef_wr) begin
            r_coef[r_ctl[3].idx] <= r_ctl[3].cval;
        end
    end

    // ------------------------------------------------------------------
    // Datapath logic
    // ------------------------------------------------------------------
    always_comb begin
        t_quad lin_q;
        t_coord lin;
        logic [Q2L-1:0] qlo;
        logic signed [Q2H-1:0] qhi;
        for (int c = 0; c < N_CUBE; c++) begin
            // x3 = x*x2, x2y = y*x2, xy2 = x*y2, y3 = y*y2
            lin   = (c % 2 == 0) ? r_x[1] : r_y[1];
            lin_q = (c < 2) ? t_quad'(r_s1_xx[F +: P2]) : t_quad'(r_s1_yy[F +: P2]);
            qlo   = lin_q[Q2L-1:0];
            qhi   = $signed(lin_q[P2-1:Q2L]);
            n_s2_clo[c] = CUBE_LO_W'(lin) * CUBE_LO_W'($signed({1'b0, qlo}));
            n_s2_chi[c] = CUBE_HI_W'(lin) * CUBE_HI_W'(qhi);
        end
    end

    always_comb begin
        logic signed [CUBE_FULL_W-1:0] full;
        t_pow cube [0:N_CUBE-1];
        for (int c = 0; c < N_CUBE; c++) begin
            full    = (CUBE_FULL_W'(r_s2_chi[c]) <<< Q2L) + CUBE_FULL_W'(r_s2_clo[c]);
            cube[c] = PW'($signed(full[F +: P3]));
        end
        n_s3_pw[TERM_ONE]    = '0;
        n_s3_pw[TERM_ONE][F] = 1'b1;
        n_s3_pw[TERM_X]      = PW'(r_x[2]);
        n_s3_pw[TERM_Y]      = PW'(r_y[2]);
        n_s3_pw[TERM_X2]     = PW'(r_s2_x2);
        n_s3_pw[TERM_XY]     = PW'(r_s2_xy);
        n_s3_pw[TERM_Y2]     = PW'(r_s2_y2);
        n_s3_pw[TERM_X3]     = cube[0];
        n_s3_pw[TERM_X2Y]    = cube[1];
        n_s3_pw[TERM_XY2]    = cube[2];
        n_s3_pw[TERM_Y3]     = cube[3];
    end

    always_comb begin
        logic [C-1:0]          cf;
        logic [PL-1:0]         plo;
        logic signed [PH-1:0]  phi;
        logic [CL-1:0]         clo;
        logic signed [CH-1:0]  chi;
        for (int a = 0; a < N_AXIS; a++) begin
            for (int t = 0; t < N_TERM; t++) begin
                cf  = r_ctl[3].dir ? r_coef[N_AXIS * N_TERM + a * N_TERM + t]
                                   : r_coef[a * N_TERM + t];
                plo = r_s3_pw[t][PL-1:0];
                phi = $signed(r_s3_pw[t][PW-1:PL]);
                clo = cf[CL-1:0];
                chi = $signed(cf[C-1:CL]);
                n_s4_ll[a][t] = LL_W'(plo) * LL_W'(clo);
                n_s4_lh[a][t] = LH_W'($signed({1'b0, plo})) * LH_W'(chi);
                n_s4_hl[a][t] = HL_W'(phi) * HL_W'($signed({1'b0, clo}));
                n_s4_hh[a][t] = HH_W'(phi) * HH_W'(chi);
            end
        end
    end

    always_comb begin
        logic signed [Q_W-1:0]   q;
        logic [Q_W-W:0]          hi;
        logic                    fits;
        n_s11_clip = 1'b0;
        for (int a = 0; a < N_AXIS; a++) begin
            q    = $signed(r_s10_s[a][CF +: Q_W]);
            hi   = q[Q_W-1:W-1];
            fits = (hi == '0) || (hi == '1);
            if (fits) begin
                n_s11_out[a] = q[W-1:0];
            end else if (q[Q_W-1]) begin
                n_s11_out[a] = {1'b1, {(W-1){1'b0}}};
            end else begin
                n_s11_out[a] = {1'b0, {(W-1){1'b1}}};
            end
            n_s11_clip = n_s11_clip | ~fits;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ctl[0].cmd  <= i_s_tuser;
            r_ctl[0].dir  <= i_s_tdata[OFF_DIR];
            r_ctl[0].idx  <= i_s_tdata[OFF_IDX +: IDX_W];
            r_ctl[0].cval <= i_s_tdata[OFF_COEF +: C];
            r_x[0]        <= $signed(i_s_tdata[OFF_X +: W]);
            r_y[0]        <= $signed(i_s_tdata[OFF_Y +: W]);
        end
        if (en[1]) begin
            r_ctl[1] <= r_ctl[0];
            r_x[1]   <= r_x[0];
            r_y[1]   <= r_y[0];
            r_s1_xx  <= SQ_W'(r_x[0]) * SQ_W'(r_x[0]);
            r_s1_xy  <= SQ_W'(r_x[0]) * SQ_W'(r_y[0]);
            r_s1_yy  <= SQ_W'(r_y[0]) * SQ_W'(r_y[0]);
        end
        if (en[2]) begin
            r_ctl[2] <= r_ctl[1];
            r_x[2]   <= r_x[1];
            r_y[2]   <= r_y[1];
            r_s2_x2  <= $signed(r_s1_xx[F +: P2]);
            r_s2_xy  <= $signed(r_s1_xy[F +: P2]);
            r_s2_y2  <= $signed(r_s1_yy[F +: P2]);
            r_s2_clo <= n_s2_clo;
            r_s2_chi <= n_s2_chi;
        end
        if (en[3]) begin
            r_ctl[3] <= r_ctl[2];
            r_s3_pw  <= n_s3_pw;
        end
        if (en[4]) begin
            r_s4_ll <= n_s4_ll;
            r_s4_lh <= n_s4_lh;
            r_s4_hl <= n_s4_hl;
            r_s4_hh <= n_s4_hh;
        end
        if (en[5]) begin
            for (int a = 0; a < N_AXIS; a++) begin
                for (int t = 0; t < N_TERM; t++) begin
                    // high-high and low-low products do not overlap
                    r_s5_a[a][t] <= $signed({r_s4_hh[a][t], r_s4_ll[a][t]});
                    // low power half meets high coefficient half, and vice versa
                    r_s5_b[a][t] <= (PROD_W'(r_s4_lh[a][t]) <<< CL)
                                  + (PROD_W'(r_s4_hl[a][t]) <<< PL);
                end
            end
        end
        if (en[6]) begin
            for (int a = 0; a < N_AXIS; a++) begin
                for (int t = 0; t < N_TERM; t++) begin
                    r_s6_p[a][t] <= r_s5_a[a][t] + r_s5_b[a][t];
                end
            end
        end
        if (en[7]) begin
            for (int a = 0; a < N_AXIS; a++) begin
                for (int i = 0; i < 5; i++) begin
                    r_s7_s[a][i] <= SUM_W'(r_s6_p[a][2*i]) + SUM_W'(r_s6_p[a][2*i+1]);
                end
            end
        end
        if (en[8]) begin
            for (int a = 0; a < N_AXIS; a++) begin
                r_s8_s[a][0] <= r_s7_s[a][0] + r_s7_s[a][1];
                r_s8_s[a][1] <= r_s7_s[a][2] + r_s7_s[a][3];
                r_s8_s[a][2] <= r_s7_s[a][4];
            end
        end
        if (en[9]) begin
            for (int a = 0; a < N_AXIS; a++) begin
                r_s9_s[a][0] <= r_s8_s[a][0] + r_s8_s[a][1];
                r_s9_s[a][1] <= r_s8_s[a][2];
            end
        end
        if (en[10]) begin
            for (int a = 0; a < N_AXIS; a++) begin
                r_s10_s[a] <= r_s9_s[a][0] + r_s9_s[a][1];
            end
        end
        if (en[11]) begin
            r_s11_out  <= n_s11_out;
            r_s11_clip <= n_s11_clip;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bccw_checker.sv
// Port-level checks for the bivariate cubic coordinate warp, and the bind
// that attaches them to the top level. Depends on bccw_pkg.
`default_nettype none

module bccw_checker #(
    parameter int COORD_WIDTH = bccw_pkg::COORD_WIDTH_DEF,
    localparam int M_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_s_tready,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,
    input logic                o_m_tuser
);
    import bccw_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result presented right after reset");

    // an empty or draining output stage lets every stage advance
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled while the output side can move");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    // a clipped result carries a saturated coordinate
    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (o_m_tdata[W-1:0] == MAX_VAL || o_m_tdata[W-1:0] == MIN_VAL ||
             o_m_tdata[2*W-1:W] == MAX_VAL || o_m_tdata[2*W-1:W] == MIN_VAL))
        else $error("clip flag without a saturated coordinate");

endmodule

bind bivariate_cubic_coordinate_warp bccw_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_bccw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
